>>> src/slid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and codes for the sorted list insert/delete unit.
// ----------------------------------------------------------------------------
package slid_pkg;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        t_op        operation;
        logic [7:0] item_value;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [4:0] entry_count;
        logic [7:0] smallest_value;
    } t_out_item;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic       ins_en;
        logic       del_en;
        logic [7:0] value;
    } t_cell_ctrl;

endpackage
`default_nettype wire

>>> src/sorted_list_insert_delete_unit.sv
// Sorted list of up to LIST_DEPTH unsigned bytes held in a row of cells, one
// byte per cell, smallest first. An insert goes ahead of any equal copies and
// is refused when full; a delete removes the first equal copy. Each accepted
// beat returns one result beat with status, new count and smallest value. Every
// cell compares against the value at once and the row shifts right (insert)
// or left (delete) at the same edge, so the result appears in the output
// register on the cycle after acceptance and a new beat can be accepted every
// cycle while the output side keeps up.
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_unit
// Top level: cell row, fill count and registered result beat.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_unit import slid_pkg::*; #(
    parameter int LIST_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_found;
    t_cell_ctrl            w_ctrl;
    logic [LIST_DEPTH-1:0] w_lt;
    logic [LIST_DEPTH-1:0] w_match;
    logic [7:0]            w_value      [LIST_DEPTH];
    logic [7:0]            w_next_value [LIST_DEPTH];
    logic                  w_left_lt    [LIST_DEPTH];
    logic [7:0]            w_left_value [LIST_DEPTH];
    logic [7:0]            w_right_value[LIST_DEPTH];
    logic [31:0]           w_count_ext;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(LIST_DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_found    = |w_match;

    always_comb begin
        w_ctrl.value  = i_in_data.item_value;
        w_ctrl.ins_en = w_accept && (i_in_data.operation == OP_INSERT) && !w_full;
        w_ctrl.del_en = w_accept && (i_in_data.operation == OP_DELETE) && w_found;
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign w_left_lt[gi]    = 1'b1;
                assign w_left_value[gi] = 8'h00;
            end else begin : g_inner
                assign w_left_lt[gi]    = w_lt[gi-1];
                assign w_left_value[gi] = w_value[gi-1];
            end
            if (gi == LIST_DEPTH - 1) begin : g_last
                assign w_right_value[gi] = w_value[gi];
            end else begin : g_notlast
                assign w_right_value[gi] = w_value[gi+1];
            end

            slid_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_occupied    (CW'(gi) < r_count),
                .i_left_lt     (w_left_lt[gi]),
                .i_left_value  (w_left_value[gi]),
                .i_right_value (w_right_value[gi]),
                .o_lt          (w_lt[gi]),
                .o_match       (w_match[gi]),
                .o_value       (w_value[gi]),
                .o_next_value  (w_next_value[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins_en) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.del_en) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_count_ext = 32'(n_count);

    always_comb begin
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (w_accept) begin
            n_out_valid = 1'b1;
            unique case (i_in_data.operation)
                OP_INSERT: n_out.status = w_full ? ST_FULL : ST_INSERTED;
                OP_DELETE: begin
                    priority if (w_empty) begin
                        n_out.status = ST_EMPTY;
                    end else if (w_found) begin
                        n_out.status = ST_DELETED;
                    end else begin
                        n_out.status = ST_NOT_FOUND;
                    end
                end
                default: n_out.status = ST_NOT_FOUND;
            endcase
            n_out.entry_count    = w_count_ext[4:0];
            n_out.smallest_value = (n_count == '0) ? 8'h00 : w_next_value[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("fill count above depth");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(2) |-> w_value[0] <= w_value[1])
        else $error("list head out of order");

    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.del_en |=> r_count == $past(r_count) - CW'(1))
        else $error("delete did not drop count");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_EMPTY)
        |-> (o_out_data.entry_count == 5'd0) && (o_out_data.smallest_value == 8'h00))
        else $error("empty beat carries data");

endmodule
`default_nettype wire

>>> src/slid_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slid_cell
// One list slot: compares its byte with the broadcast value and takes its own,
// the new, the left or the right neighbour's byte.
// ----------------------------------------------------------------------------
module slid_cell import slid_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  logic       i_left_lt,
    input  logic [7:0] i_left_value,
    input  logic [7:0] i_right_value,
    output logic       o_lt,
    output logic       o_match,
    output logic [7:0] o_value,
    output logic [7:0] o_next_value
);

    logic [7:0] r_value;
    logic [7:0] n_value;

    always_comb begin
        o_lt    = i_occupied && (r_value < i_ctrl.value);
        o_match = i_occupied && (r_value == i_ctrl.value);
    end

    always_comb begin
        priority if (i_ctrl.ins_en && !o_lt) begin
            n_value = i_left_lt ? i_ctrl.value : i_left_value;
        end else if (i_ctrl.del_en && !o_lt) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;

endmodule
`default_nettype wire
